### hw/rtl/dts_pkg.sv
`timescale 1ns / 1ps

package dts_pkg;

  // Configuration of the scheduler
  localparam int unsigned TASK_COUNT = 7;
  localparam int unsigned TIME_BITS  = 32;

  localparam int unsigned IDX_W    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int unsigned LAST_IDX = TASK_COUNT - 1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SCHED_ABS = 2'd0,
    REQ_SCHED_DLY = 2'd1,
    REQ_CANCEL    = 2'd2,
    REQ_SERVICE   = 2'd3
  } dts_req_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } dts_state_e;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } dts_alu_e;

  typedef struct packed {
    dts_req_e    req_type;
    logic [2:0]  task_id;
    logic [31:0] time_value;
    logic [31:0] now_time;
  } dts_req_t;

  typedef struct packed {
    logic [2:0] due_task;
    logic       fired;
    logic       last;
  } dts_res_t;

  // Datapath controls from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    dts_alu_e         alu_op;
    logic             a_now;   // operand A: now (1) or zero (0)
    logic             b_mem;   // operand B: stored deadline (1) or time_value (0)
  } dts_dp_ctrl_t;

  function automatic logic [TIME_BITS-1:0] to_time(input logic [31:0] v);
    return TIME_BITS'(v);
  endfunction

endpackage

### hw/rtl/deadline_task_scheduler.sv
`timescale 1ns / 1ps

// Deadline task scheduler. A request is taken when start_i is high and busy_o
// is low. Schedule and cancel requests hold busy_o high for one cycle and give
// no result. A service request holds busy_o high through its EXEC state, a
// READ and a CMP step for each task slot, and an EMIT step for each result.
// The EXEC state decodes the request. In each slot, the READ step reads its
// deadline from the single-port store and the CMP step compares it against
// now_time in the shared adder. Then one result is strobed per cycle. Every
// result appears on res_o for exactly one cycle, marked by res_valid_o, the
// cycle after its emit step. It cannot be held off, so the receiver must take
// it then. The final result of a service request has last set. When nothing
// was due, a single result with fired low is given.
module deadline_task_scheduler import dts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dts_req_t req_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output dts_res_t res_o
);

  dts_dp_ctrl_t dp_ctrl;
  logic         due;
  logic [31:0]  time_value;
  logic [31:0]  now_time;

  dts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .due_i        (due),
    .busy_o       (busy_o),
    .dp_o         (dp_ctrl),
    .time_value_o (time_value),
    .now_time_o   (now_time),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  dts_datapath u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (dp_ctrl),
    .time_value_i (time_value),
    .now_time_i   (now_time),
    .due_o        (due)
  );

endmodule

### hw/rtl/dts_datapath.sv
`timescale 1ns / 1ps

module dts_datapath import dts_pkg::*; (
  input  logic         clk_i,
  input  dts_dp_ctrl_t ctrl_i,
  input  logic [31:0]  time_value_i,
  input  logic [31:0]  now_time_i,
  output logic         due_o
);

  logic [TIME_BITS-1:0] mem_q [TASK_COUNT];
  logic [TIME_BITS-1:0] rdata_q;
  logic [TIME_BITS-1:0] op_a;
  logic [TIME_BITS-1:0] op_b;
  logic [TIME_BITS-1:0] alu_res;

  // Shared adder: deadline computation and wrap-aware difference
  always_comb begin
    op_a = ctrl_i.a_now ? to_time(now_time_i) : '0;
    op_b = ctrl_i.b_mem ? rdata_q : to_time(time_value_i);
    unique case (ctrl_i.alu_op)
      ALU_ADD: alu_res = op_a + op_b;
      ALU_SUB: alu_res = op_a - op_b;
      default: alu_res = op_a + op_b;
    endcase
  end

  // Due when now - deadline is not negative
  assign due_o = ~alu_res[TIME_BITS-1];

  // Deadline store, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.addr] <= alu_res;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[ctrl_i.addr];
    end
  end

endmodule

### hw/rtl/dts_ctrl.sv
`timescale 1ns / 1ps

module dts_ctrl import dts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  dts_req_t     req_i,
  input  logic         due_i,
  output logic         busy_o,
  output dts_dp_ctrl_t dp_o,
  output logic [31:0]  time_value_o,
  output logic [31:0]  now_time_o,
  output logic         res_valid_o,
  output dts_res_t     res_o
);

  dts_state_e            state_q, state_d;
  dts_req_t              req_q, req_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TASK_COUNT-1:0] pend_q, pend_d;
  logic [TASK_COUNT-1:0] due_q, due_d;
  logic                  res_valid_q, res_valid_d;
  dts_res_t              res_q, res_d;

  logic                  id_ok;
  logic [TASK_COUNT-1:0] id_hot;
  logic [TASK_COUNT-1:0] low_hot;
  logic [2:0]            low_idx;
  logic                  single_due;

  // Task decode, out-of-range numbers select nothing
  always_comb begin
    id_hot = '0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      if (req_q.task_id == 3'(i)) begin
        id_hot[i] = 1'b1;
      end
    end
    id_ok = |id_hot;
  end

  // Lowest due task
  always_comb begin
    low_hot = '0;
    low_idx = '0;
    for (int i = TASK_COUNT - 1; i >= 0; i--) begin
      if (due_q[i]) begin
        low_hot = '0;
        low_hot[i] = 1'b1;
        low_idx = 3'(i);
      end
    end
    single_due = ((due_q & ~low_hot) == '0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = (req_q.req_type == REQ_SERVICE) ? ST_READ : ST_IDLE;
      ST_READ: state_d = ST_CMP;
      ST_CMP:  state_d = (idx_q == IDX_W'(LAST_IDX)) ? ST_EMIT : ST_READ;
      ST_EMIT: if (single_due) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and data register updates
  always_comb begin
    req_d       = req_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    due_d       = due_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    dp_o        = '{wr_en: 1'b0, rd_en: 1'b0, addr: idx_q, alu_op: ALU_ADD,
                    a_now: 1'b0, b_mem: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) req_d = req_i;
      end
      ST_EXEC: begin
        dp_o.addr = req_q.task_id[IDX_W-1:0];
        unique case (req_q.req_type)
          REQ_SCHED_ABS, REQ_SCHED_DLY: begin
            dp_o.wr_en = id_ok;
            dp_o.a_now = (req_q.req_type == REQ_SCHED_DLY);
            pend_d     = pend_q | id_hot;
          end
          REQ_CANCEL: pend_d = pend_q & ~id_hot;
          REQ_SERVICE: begin
            idx_d = '0;
            due_d = '0;
          end
          default: ;
        endcase
      end
      ST_READ: begin
        dp_o.rd_en = 1'b1;
      end
      ST_CMP: begin
        dp_o.alu_op = ALU_SUB;
        dp_o.a_now  = 1'b1;
        dp_o.b_mem  = 1'b1;
        if (pend_q[idx_q] && due_i) begin
          due_d[idx_q]  = 1'b1;
          pend_d[idx_q] = 1'b0;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_EMIT: begin
        res_valid_d = 1'b1;
        if (due_q == '0) begin
          res_d = '{due_task: 3'd0, fired: 1'b0, last: 1'b1};
        end else begin
          res_d = '{due_task: low_idx, fired: 1'b1, last: single_due};
          due_d = due_q & ~low_hot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pend_q      <= '0;
      due_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      due_q       <= due_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign time_value_o = req_q.time_value;
  assign now_time_o   = req_q.now_time;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  // A result strobe only follows an emit cycle
  a_res_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without emit");

  // A task found due is no longer pending
  a_due_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q & pend_q) == '0)
    else $error("due task still pending");

  // An empty service result is always the final one
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.fired) |-> res_o.last)
    else $error("empty result not marked last");

  // Idle means no due tasks are left over
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (due_q == '0))
    else $error("due tasks left after service");

endmodule
